@@ design/temp2rgb_pkg.sv @@
// Shared types and constants for the temperature to RGB LED duty block.
`default_nettype none

package temp2rgb_pkg;

    // Width of temperature samples and limit registers
    localparam int TEMP_W = 16;

    // Configuration register index width
    localparam int CFG_IDX_W = 1;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_TEMPERATURE  = 1'b0,
        REG_HIGH_TEMPERATURE = 1'b1
    } cfg_reg_t;

    // Where the sample sits relative to the limits
    typedef enum logic [1:0] {
        RANGE_DIV  = 2'd0,   // strictly between limits, quotient is used
        RANGE_LOW  = 2'd1,   // at or below low limit
        RANGE_HIGH = 2'd2    // at or above high limit
    } range_t;

    // Control travelling alongside each sample through the divider chain
    typedef struct packed {
        logic   valid;
        range_t mode;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ design/temp2rgb_if.sv @@
// Handshake channel interfaces: sample input, duty output, configuration writes.
`default_nettype none

interface temp2rgb_in_if
    import temp2rgb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TEMP_W-1:0] temperature;

    modport source (output valid, output temperature, input ready);
    modport sink (input valid, input temperature, output ready);
endinterface

interface temp2rgb_out_if #(
    parameter int DUTY_BITS = 10
) ();
    logic                 valid;
    logic                 ready;
    logic [DUTY_BITS:0]   red_duty;
    logic [DUTY_BITS:0]   green_duty;
    logic [DUTY_BITS:0]   blue_duty;

    modport source (output valid, output red_duty, output green_duty, output blue_duty,
                    input ready);
    modport sink (input valid, input red_duty, input green_duty, input blue_duty,
                  output ready);
endinterface

interface temp2rgb_cfg_if
    import temp2rgb_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TEMP_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/temperature_to_rgb_led_duty.sv @@
// Top level: maps temperature samples to RGB LED PWM duties on a blue-to-red ramp.
//
// Channels: "sample" takes one signed 1/16-degree temperature per transaction;
// "result" returns red/green/blue duty (0..2^DUTY_BITS, full scale = LED off);
// "cfg" writes the low (index 0) and high (index 1) limits, always ready.
// Limits may only be written while no sample is in flight.
// Pipeline: input compare stage, one restoring divider cell per quotient bit,
// then ramp and output register, all registered in that order. Throughput:
// one transaction per cycle while the result channel is not stalled; the
// chain of DUTY_BITS divider cells each retires one quotient bit.
// Stall: when result is valid and not taken, the whole chain holds and
// sample.ready drops; a free output slot or a taken result moves it again.
// Reset: clears all valid flags and loads the limits to 320 and 560.
`default_nettype none

module temperature_to_rgb_led_duty
    import temp2rgb_pkg::*;
#(
    parameter int DUTY_BITS = 10
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    temp2rgb_in_if.sink     sample,
    temp2rgb_out_if.source  result,
    temp2rgb_cfg_if.sink    cfg
);

    localparam logic signed [TEMP_W-1:0] LOW_RESET  = TEMP_W'(320);
    localparam logic signed [TEMP_W-1:0] HIGH_RESET = TEMP_W'(560);

    logic signed [TEMP_W-1:0] low_reg;
    logic signed [TEMP_W-1:0] high_reg;
    logic [TEMP_W:0]          den_full;
    logic [TEMP_W-1:0]        den;
    logic                     en;
    logic                     out_valid;

    cell_ctl_t                ctl_chain [0:DUTY_BITS];
    logic [TEMP_W-1:0]        rem_chain [0:DUTY_BITS];
    logic [DUTY_BITS-1:0]     quo_chain [0:DUTY_BITS];

    cell_ctl_t                ctl_next;
    logic signed [TEMP_W:0]   num_full;
    logic signed [TEMP_W-1:0] temp_s;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= LOW_RESET;
            high_reg <= HIGH_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_LOW_TEMPERATURE:  low_reg  <= cfg.data;
                REG_HIGH_TEMPERATURE: high_reg <= cfg.data;
                default:              ;
            endcase
        end
    end

    // Divisor is only used when low < t < high, so it fits 16 bits unsigned
    assign den_full = {high_reg[TEMP_W-1], high_reg} - {low_reg[TEMP_W-1], low_reg};
    assign den      = den_full[TEMP_W-1:0];

    // Chain advances whenever the output slot is free or being drained
    assign en           = !out_valid || result.ready;
    assign sample.ready = en;

    // Input stage: range classification and numerator
    always_comb
    begin
        temp_s         = sample.temperature;
        num_full       = {temp_s[TEMP_W-1], temp_s} - {low_reg[TEMP_W-1], low_reg};
        ctl_next.valid = sample.valid;
        if (temp_s <= low_reg)
        begin
            ctl_next.mode = RANGE_LOW;
        end
        else if (temp_s >= high_reg)
        begin
            ctl_next.mode = RANGE_HIGH;
        end
        else
        begin
            ctl_next.mode = RANGE_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_chain[0] <= '0;
        end
        else if (en)
        begin
            ctl_chain[0] <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_chain[0] <= num_full[TEMP_W-1:0];
            quo_chain[0] <= '0;
        end
    end

    // Divider chain: one quotient bit per cell
    for (genvar i = 0; i < DUTY_BITS; i++)
    begin : g_cell
        temp2rgb_div_cell #(
            .DUTY_BITS (DUTY_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .den     (den),
            .ctl_in  (ctl_chain[i]),
            .rem_in  (rem_chain[i]),
            .quo_in  (quo_chain[i]),
            .ctl_reg (ctl_chain[i+1]),
            .rem_reg (rem_chain[i+1]),
            .quo_reg (quo_chain[i+1])
        );
    end

    // Ramp and output register
    temp2rgb_ramp #(
        .DUTY_BITS (DUTY_BITS)
    ) u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (ctl_chain[DUTY_BITS]),
        .quo_in    (quo_chain[DUTY_BITS]),
        .valid_reg (out_valid),
        .red_reg   (result.red_duty),
        .green_reg (result.green_duty),
        .blue_reg  (result.blue_duty)
    );

    assign result.valid = out_valid;

endmodule

`default_nettype wire

@@ design/temp2rgb_div_cell.sv @@
// One restoring division step: shifts the remainder, subtracts the divisor, emits a quotient bit.
`default_nettype none

module temp2rgb_div_cell
    import temp2rgb_pkg::*;
#(
    parameter int DUTY_BITS = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic [TEMP_W-1:0]    den,
    input  wire cell_ctl_t            ctl_in,
    input  wire logic [TEMP_W-1:0]    rem_in,
    input  wire logic [DUTY_BITS-1:0] quo_in,
    output cell_ctl_t                 ctl_reg,
    output logic [TEMP_W-1:0]         rem_reg,
    output logic [DUTY_BITS-1:0]      quo_reg
);

    logic [TEMP_W:0]      rem_dbl;
    logic [TEMP_W:0]      rem_sub;
    logic                 q_bit;
    logic [TEMP_W-1:0]    rem_next;
    logic [DUTY_BITS-1:0] quo_next;

    // Trial subtract; remainder stays below den so it fits TEMP_W bits
    always_comb
    begin
        rem_dbl  = {rem_in, 1'b0};
        rem_sub  = rem_dbl - {1'b0, den};
        q_bit    = (rem_dbl >= {1'b0, den});
        rem_next = q_bit ? rem_sub[TEMP_W-1:0] : rem_dbl[TEMP_W-1:0];
        quo_next = {quo_in[DUTY_BITS-2:0], q_bit};
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // Data registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

`default_nettype wire

@@ design/temp2rgb_ramp.sv @@
// Hue ramp and common-anode inversion, with the output register.
`default_nettype none

module temp2rgb_ramp
    import temp2rgb_pkg::*;
#(
    parameter int DUTY_BITS = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire cell_ctl_t            ctl_in,
    input  wire logic [DUTY_BITS-1:0] quo_in,
    output logic                      valid_reg,
    output logic [DUTY_BITS:0]        red_reg,
    output logic [DUTY_BITS:0]        green_reg,
    output logic [DUTY_BITS:0]        blue_reg
);

    localparam logic [DUTY_BITS:0] FULL = {1'b1, {DUTY_BITS{1'b0}}};

    logic [DUTY_BITS:0]   x_val;
    logic [DUTY_BITS+2:0] hue;
    logic [2:0]           seg;
    logic [DUTY_BITS:0]   frac;
    logic [DUTY_BITS:0]   r_int;
    logic [DUTY_BITS:0]   g_int;
    logic [DUTY_BITS:0]   b_int;
    logic [DUTY_BITS:0]   red_next;
    logic [DUTY_BITS:0]   green_next;
    logic [DUTY_BITS:0]   blue_next;

    // Normalized position, hue and segment split
    always_comb
    begin
        unique case (ctl_in.mode)
            RANGE_LOW:  x_val = '0;
            RANGE_HIGH: x_val = FULL;
            default:    x_val = {1'b0, quo_in};
        endcase
        hue  = {FULL - x_val, 2'b00};
        seg  = hue[DUTY_BITS+2:DUTY_BITS];
        frac = {1'b0, hue[DUTY_BITS-1:0]};
    end

    // HSV ramp at full saturation and value
    always_comb
    begin
        unique case (seg)
            3'd0:
            begin
                r_int = FULL;        g_int = frac;        b_int = '0;
            end
            3'd1:
            begin
                r_int = FULL - frac; g_int = FULL;        b_int = '0;
            end
            3'd2:
            begin
                r_int = '0;          g_int = FULL;        b_int = frac;
            end
            3'd3:
            begin
                r_int = '0;          g_int = FULL - frac; b_int = FULL;
            end
            default:
            begin
                r_int = frac;        g_int = '0;          b_int = FULL;
            end
        endcase
        red_next   = FULL - r_int;
        green_next = FULL - g_int;
        blue_next  = FULL - b_int;
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

endmodule

`default_nettype wire
